@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files; only the top level includes them
// no dependencies; the users supply clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define DFD_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// assertion on the module clock and reset
`define DFD_ASSERT(lbl, prop, msg) \
  `DFD_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/dfd_pkg.sv @@
// types, codes and constants of the flash download sequencer
// no dependencies; used by the channel interfaces and the top level
package dfd_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CHUNK_BYTES = 5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK   = 4'd1;

  localparam logic [31:0] IMAGE_SIZE_RESET = 32'h0000_0000;
  localparam logic [31:0] KEY_MASK_RESET   = 32'hA5A5_A5A5;

  // request service ids and sub-function bytes
  localparam logic [7:0] SID_SESSION_REQ  = 8'h10;
  localparam logic [7:0] SID_SECURITY_REQ = 8'h27;
  localparam logic [7:0] SID_DOWNLOAD_REQ = 8'h34;
  localparam logic [7:0] SID_TRANSFER_REQ = 8'h36;
  localparam logic [7:0] SID_EXIT_REQ     = 8'h37;
  localparam logic [7:0] SUB_PROG_SESSION = 8'h02;
  localparam logic [7:0] SUB_SEED         = 8'h01;
  localparam logic [7:0] SUB_KEY          = 8'h02;
  localparam logic [7:0] DL_FORMAT        = 8'h00;
  localparam logic [7:0] DL_ADDR_LEN_FMT  = 8'h44;

  // response service ids
  localparam logic [7:0] SID_NEGATIVE     = 8'h7F;
  localparam logic [7:0] SID_SESSION_POS  = 8'h50;
  localparam logic [7:0] SID_SECURITY_POS = 8'h67;
  localparam logic [7:0] SID_DOWNLOAD_POS = 8'h74;
  localparam logic [7:0] SID_TRANSFER_POS = 8'h76;
  localparam logic [7:0] SID_EXIT_POS     = 8'h77;

  localparam logic [3:0] SEED_RSP_LEN = 4'd6;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_RESP    = 3'd1,
    CMD_TIMEOUT = 3'd2,
    CMD_CHUNK   = 3'd3,
    CMD_RDERR   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SESSION    = 3'd1,
    PH_SEED       = 3'd2,
    PH_KEY        = 3'd3,
    PH_DOWNLOAD   = 3'd4,
    PH_NEED_CHUNK = 3'd5,
    PH_DATA       = 3'd6,
    PH_EXIT       = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    ST_WAIT    = 4'd0,
    ST_NEED    = 4'd1,
    ST_DONE    = 4'd2,
    ST_NEG     = 4'd3,
    ST_UNEXP   = 4'd4,
    ST_TIMEOUT = 4'd5,
    ST_SHORT   = 4'd6,
    ST_RDERR   = 4'd7,
    ST_BUSY    = 4'd8,
    ST_IGNORED = 4'd9
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  rx_len;
    logic [7:0]  rx_sid;
    logic [7:0]  rx_b1;
    logic [7:0]  rx_b2;
    logic [7:0]  rx_b3;
    logic [7:0]  rx_b4;
    logic [7:0]  rx_b5;
    logic [39:0] chunk_data;
  } dfd_req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [2:0]  tx_len;
    logic [55:0] tx_frame;
    status_e     status;
    logic [7:0]  nrc_code;
    logic [31:0] bytes_sent;
  } dfd_rsp_t;

  function automatic logic [7:0] expected_sid(phase_e ph);
    logic [7:0] sid;
    unique case (ph)
      PH_SESSION:      sid = SID_SESSION_POS;
      PH_SEED, PH_KEY: sid = SID_SECURITY_POS;
      PH_DOWNLOAD:     sid = SID_DOWNLOAD_POS;
      PH_DATA:         sid = SID_TRANSFER_POS;
      default:         sid = SID_EXIT_POS;
    endcase
    return sid;
  endfunction

endpackage

@@ hw/rtl/dfd_req_if.sv @@
// event channel into the sequencer: valid, ready and one event
// depends on dfd_pkg for the payload type
interface dfd_req_if import dfd_pkg::*; ();
  logic     valid;
  logic     ready;
  dfd_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dfd_rsp_if.sv @@
// result channel out of the sequencer: valid, ready and one result
// depends on dfd_pkg for the payload type
interface dfd_rsp_if import dfd_pkg::*; ();
  logic     valid;
  logic     ready;
  dfd_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dfd_cfg_if.sv @@
// register write channel: valid, ready, register index and write data
// depends on dfd_pkg for the index width
interface dfd_cfg_if import dfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/diag_flash_download_sequencer.sv @@
// top level of the diagnostic flash download sequencer
// depends on dfd_pkg, dfd_req_if, dfd_rsp_if, dfd_cfg_if and assert_macros.svh
//
// usage:
//   req_i carries one event per transaction: start, response frame, response
//   timeout, firmware chunk or chunk read error. every event yields exactly one
//   result on rsp_o: an optional request frame to send, a status, the negative
//   response code and the count of acknowledged image bytes.
//   cfg_i writes image_size (index 0) and key_mask (index 1); it is always
//   ready, and writes to other indexes are dropped.
//   the result is registered: the result of an event accepted at an edge is
//   valid after that edge. throughput is one event per cycle unless rsp_o stalls,
//   set by the single decode stage that feeds the result register.
//   when the receiver stalls, the result register holds its transaction and
//   req_i.ready drops until the result is taken; ready returns in the same
//   cycle that rsp_o.ready is high.
//   reset puts the job in idle with byte offset 0 and sequence byte 1,
//   image_size 0 and key_mask a5a5a5a5; the result register comes up empty.
module diag_flash_download_sequencer import dfd_pkg::*; #(
  parameter int unsigned DATA_PER_FRAME = 5
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dfd_req_if.sink   req_i,
  dfd_rsp_if.source rsp_o,
  dfd_cfg_if.sink   cfg_i
);

  `include "assert_macros.svh"

  localparam logic [2:0] DpfLen = 3'(DATA_PER_FRAME);

  phase_e      phase_q, phase_d;
  logic [31:0] byte_offset_q, byte_offset_d;
  logic [7:0]  block_counter_q, block_counter_d;
  logic [2:0]  pending_len_q, pending_len_d;
  logic [31:0] image_size_q;
  logic [31:0] key_mask_q;

  logic        rsp_valid_q;
  dfd_rsp_t    rsp_data_q, rsp_data_d;

  logic        req_accept;
  dfd_req_t    req;
  cmd_e        cmd;
  logic        waiting;
  logic        is_neg;
  logic        is_unexp;
  logic [31:0] off_acked;
  logic [32:0] remain;
  logic        more_data;
  logic [2:0]  pend_next;
  logic [7:0]  blk_next;
  logic [2:0]  chunk_n;
  logic [39:0] chunk_kept;
  logic [31:0] seed_key;

  assign req         = req_i.data;
  assign cmd         = cmd_e'(req.cmd);
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // decode helpers
  assign waiting  = (phase_q != PH_IDLE) && (phase_q != PH_NEED_CHUNK);
  assign is_neg   = (req.rx_len != 4'd0) && (req.rx_sid == SID_NEGATIVE);
  assign is_unexp = (req.rx_len == 4'd0) || (req.rx_sid != expected_sid(phase_q));

  assign off_acked = (phase_q == PH_DATA) ? byte_offset_q + {29'd0, pending_len_q}
                                          : byte_offset_q;
  assign remain    = {1'b0, image_size_q} - {1'b0, off_acked};
  assign more_data = !remain[32] && (remain[31:0] != 32'd0);
  assign pend_next = ((remain[31:3] != 29'd0) || (remain[2:0] > DpfLen)) ? DpfLen
                                                                          : remain[2:0];
  assign blk_next  = (block_counter_q == 8'hFF) ? 8'h01 : block_counter_q + 8'h01;
  assign seed_key  = {req.rx_b2, req.rx_b3, req.rx_b4, req.rx_b5} ^ key_mask_q;
  assign chunk_n   = (pending_len_q > 3'(CHUNK_BYTES)) ? 3'(CHUNK_BYTES) : pending_len_q;

  always_comb begin
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      chunk_kept[39-8*k -: 8] = (3'(k) < chunk_n) ? req.chunk_data[39-8*k -: 8] : 8'h00;
    end
  end

  // next state
  always_comb begin
    phase_d         = phase_q;
    byte_offset_d   = byte_offset_q;
    block_counter_d = block_counter_q;
    pending_len_d   = pending_len_q;
    unique case (cmd)
      CMD_START: begin
        if (phase_q == PH_IDLE) begin
          byte_offset_d   = 32'd0;
          block_counter_d = 8'h01;
          pending_len_d   = 3'd0;
          phase_d         = PH_SESSION;
        end
      end
      CMD_RESP: begin
        if (waiting) begin
          if (is_neg || is_unexp) begin
            phase_d = PH_IDLE;
          end else begin
            unique case (phase_q)
              PH_SESSION: phase_d = PH_SEED;
              PH_SEED:    phase_d = (req.rx_len < SEED_RSP_LEN) ? PH_IDLE : PH_KEY;
              PH_KEY:     phase_d = PH_DOWNLOAD;
              PH_DOWNLOAD, PH_DATA: begin
                if (phase_q == PH_DATA) begin
                  byte_offset_d   = off_acked;
                  block_counter_d = blk_next;
                end
                if (more_data) begin
                  pending_len_d = pend_next;
                  phase_d       = PH_NEED_CHUNK;
                end else begin
                  phase_d = PH_EXIT;
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end
      CMD_TIMEOUT: begin
        if (waiting) phase_d = PH_IDLE;
      end
      CMD_CHUNK: begin
        if (phase_q == PH_NEED_CHUNK) phase_d = PH_DATA;
      end
      CMD_RDERR: begin
        if (phase_q == PH_NEED_CHUNK) phase_d = PH_IDLE;
      end
      default: ;
    endcase
  end

  // result of the event
  always_comb begin
    rsp_data_d            = '0;
    rsp_data_d.status     = ST_IGNORED;
    rsp_data_d.bytes_sent = byte_offset_d;
    unique case (cmd)
      CMD_START: begin
        if (phase_q == PH_IDLE) begin
          rsp_data_d.tx_len   = 3'd2;
          rsp_data_d.tx_frame = {SID_SESSION_REQ, SUB_PROG_SESSION, 40'd0};
          rsp_data_d.status   = ST_WAIT;
        end else begin
          rsp_data_d.status = ST_BUSY;
        end
      end
      CMD_RESP: begin
        if (waiting) begin
          if (is_neg) begin
            rsp_data_d.status   = ST_NEG;
            rsp_data_d.nrc_code = req.rx_b2;
          end else if (is_unexp) begin
            rsp_data_d.status = ST_UNEXP;
          end else begin
            unique case (phase_q)
              PH_SESSION: begin
                rsp_data_d.tx_len   = 3'd2;
                rsp_data_d.tx_frame = {SID_SECURITY_REQ, SUB_SEED, 40'd0};
                rsp_data_d.status   = ST_WAIT;
              end
              PH_SEED: begin
                if (req.rx_len < SEED_RSP_LEN) begin
                  rsp_data_d.status = ST_SHORT;
                end else begin
                  rsp_data_d.tx_len   = 3'd6;
                  rsp_data_d.tx_frame = {SID_SECURITY_REQ, SUB_KEY, seed_key, 8'h00};
                  rsp_data_d.status   = ST_WAIT;
                end
              end
              PH_KEY: begin
                rsp_data_d.tx_len   = 3'd7;
                rsp_data_d.tx_frame = {SID_DOWNLOAD_REQ, DL_FORMAT, DL_ADDR_LEN_FMT,
                                       image_size_q};
                rsp_data_d.status   = ST_WAIT;
              end
              PH_DOWNLOAD, PH_DATA: begin
                if (more_data) begin
                  rsp_data_d.status = ST_NEED;
                end else begin
                  rsp_data_d.tx_len   = 3'd1;
                  rsp_data_d.tx_frame = {SID_EXIT_REQ, 48'd0};
                  rsp_data_d.status   = ST_WAIT;
                end
              end
              default: rsp_data_d.status = ST_DONE;
            endcase
          end
        end
      end
      CMD_TIMEOUT: begin
        if (waiting) rsp_data_d.status = ST_TIMEOUT;
      end
      CMD_CHUNK: begin
        if (phase_q == PH_NEED_CHUNK) begin
          rsp_data_d.tx_len   = 3'd2 + chunk_n;
          rsp_data_d.tx_frame = {SID_TRANSFER_REQ, block_counter_q, chunk_kept};
          rsp_data_d.status   = ST_WAIT;
        end
      end
      CMD_RDERR: begin
        if (phase_q == PH_NEED_CHUNK) rsp_data_d.status = ST_RDERR;
      end
      default: ;
    endcase
    rsp_data_d.tx_valid = (rsp_data_d.tx_len != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      byte_offset_q   <= 32'd0;
      block_counter_q <= 8'h01;
      pending_len_q   <= 3'd0;
    end else if (req_accept) begin
      phase_q         <= phase_d;
      byte_offset_q   <= byte_offset_d;
      block_counter_q <= block_counter_d;
      pending_len_q   <= pending_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= IMAGE_SIZE_RESET;
      key_mask_q   <= KEY_MASK_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == REG_IMAGE_SIZE) image_size_q <= cfg_i.data;
      if (cfg_i.index == REG_KEY_MASK)   key_mask_q   <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) rsp_data_q <= rsp_data_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  `DFD_ASSERT(a_tx_valid_len,
    rsp_valid_q |-> (rsp_data_q.tx_valid == (rsp_data_q.tx_len != 3'd0)),
    "tx_valid disagrees with tx_len")
  `DFD_ASSERT(a_frame_only_waiting,
    (rsp_valid_q && rsp_data_q.tx_valid) |-> (rsp_data_q.status == ST_WAIT),
    "request frame sent with a status other than waiting")
  `DFD_ASSERT(a_pending_range,
    (phase_q == PH_NEED_CHUNK) |-> ((pending_len_q != 3'd0) && (pending_len_q <= DpfLen)),
    "chunk wait with a pending length out of range")
  `DFD_ASSERT(a_start_opens_session,
    (req_accept && (cmd == CMD_START) && (phase_q == PH_IDLE))
      |=> ((phase_q == PH_SESSION) && (block_counter_q == 8'h01) && rsp_valid_q),
    "start from idle did not open a session")

endmodule
